// File: src/steq_pkg.sv
`default_nettype none
package steq_pkg;
   localparam int MAX_TIMERS = 64;
   localparam int RING_AW    = 6;
   localparam int RING_DEPTH = 1 << RING_AW;
   localparam int CNT_W      = 7;
   localparam int CONN_W     = 16;
   localparam int TIME_W     = 32;
   localparam int ENTRY_W    = CONN_W + TIME_W;

   localparam logic [1:0] CMD_ADD    = 2'd0;
   localparam logic [1:0] CMD_ADJUST = 2'd1;
   localparam logic [1:0] CMD_DELETE = 2'd2;
   localparam logic [1:0] CMD_TICK   = 2'd3;

   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_FULL     = 2'd1;
   localparam logic [1:0] ST_NOTFOUND = 2'd2;
   localparam logic [1:0] ST_DUP      = 2'd3;

   typedef logic [CNT_W-1:0] cnt_type;
endpackage
`default_nettype wire

// File: src/steq_ram.sv
`default_nettype none
module steq_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end
endmodule
`default_nettype wire

// File: src/sorted_timer_expiry_queue.sv
// Sorted timer expiry queue.
// Input channel req_*: one command per item (add, adjust, delete, tick).
// Result channel rsp_*: add, adjust and delete give one result; tick gives
// one result per expired connection in expiry order, or one empty result,
// and rsp_last marks the final result of an item.
// Timers live in a 64-entry ring memory kept in ascending expiry order,
// with a head pointer, so expiring the earliest timer costs no shifting.
// Every memory step reads an entry, then checks it or writes it back, so
// an item's work grows with the entries it touches: the id search walks up
// to the held count, a removal shifts the entries behind it down, and an
// insertion scans to its place and shifts the entries behind it up.
// A tick examines timers from the head until one has not yet expired or
// the queue runs empty, then hands over its final result.
// A new item is accepted once the previous one has handed over its last
// result, even while that result waits in the output register.
// When the receiver stalls, the sequencer holds until the output register
// frees up. Reset empties the queue at once; no clearing pass is needed.
`default_nettype none
module sorted_timer_expiry_queue
   import steq_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [1:0]  req_cmd,
   input  wire logic [15:0] req_conn_id,
   input  wire logic [31:0] req_expire_time,
   input  wire logic [31:0] req_current_time,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [1:0]       rsp_status,
   output logic             rsp_expired_valid,
   output logic [15:0]      rsp_expired_conn,
   output logic [6:0]       rsp_occupancy,
   output logic             rsp_last
);
   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_F_RD  = 4'd1;
   localparam logic [3:0] S_F_CHK = 4'd2;
   localparam logic [3:0] S_R_RD  = 4'd3;
   localparam logic [3:0] S_R_WR  = 4'd4;
   localparam logic [3:0] S_I_RD  = 4'd5;
   localparam logic [3:0] S_I_CHK = 4'd6;
   localparam logic [3:0] S_U_RD  = 4'd7;
   localparam logic [3:0] S_U_WR  = 4'd8;
   localparam logic [3:0] S_EMIT  = 4'd9;
   localparam logic [3:0] S_T_RD  = 4'd10;
   localparam logic [3:0] S_T_CHK = 4'd11;
   localparam logic [3:0] S_T_END = 4'd12;

   localparam cnt_type FULL_CNT = cnt_type'(MAX_TIMERS);

   logic [3:0]         state_ff, state_in;
   cnt_type            idx_ff, idx_in;
   cnt_type            pos_ff, pos_in;
   cnt_type            count_ff, count_in;
   logic [RING_AW-1:0] head_ff, head_in;
   logic [1:0]         st_ff, st_in;
   logic [1:0]         cmd_ff;
   logic [CONN_W-1:0]  id_ff;
   logic [TIME_W-1:0]  t_ff, now_ff;
   logic               pend_ff, pend_in;
   logic [CONN_W-1:0]  pend_conn_ff, pend_conn_in;
   cnt_type            pend_occ_ff, pend_occ_in;

   logic               rsp_valid_ff;
   logic [1:0]         rsp_status_ff;
   logic               rsp_xv_ff;
   logic [CONN_W-1:0]  rsp_conn_ff;
   cnt_type            rsp_occ_ff;
   logic               rsp_last_ff;

   logic               emit;
   logic [1:0]         e_status;
   logic               e_valid;
   logic [CONN_W-1:0]  e_conn;
   cnt_type            e_occ;
   logic               e_last;

   logic               wr_en, rd_en;
   logic [RING_AW-1:0] wr_addr, rd_addr;
   logic [ENTRY_W-1:0] wr_data, rd_data;
   logic [CONN_W-1:0]  rd_conn;
   logic [TIME_W-1:0]  rd_exp;
   logic               out_free;
   logic               accept;
   cnt_type            idx_p1, idx_m1;

   assign rd_conn  = rd_data[ENTRY_W-1:TIME_W];
   assign rd_exp   = rd_data[TIME_W-1:0];
   assign out_free = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == S_IDLE);
   assign accept   = req_valid && req_ready;
   assign idx_p1   = idx_ff + cnt_type'(1);
   assign idx_m1   = idx_ff - cnt_type'(1);

   steq_ram #(.WIDTH(ENTRY_W), .DEPTH(RING_DEPTH)) u_ring (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_comb begin
      state_in     = state_ff;
      idx_in       = idx_ff;
      pos_in       = pos_ff;
      count_in     = count_ff;
      head_in      = head_ff;
      st_in        = st_ff;
      pend_in      = pend_ff;
      pend_conn_in = pend_conn_ff;
      pend_occ_in  = pend_occ_ff;
      emit         = 1'b0;
      e_status     = ST_OK;
      e_valid      = 1'b0;
      e_conn       = '0;
      e_occ        = count_ff;
      e_last       = 1'b1;
      wr_en        = 1'b0;
      wr_addr      = head_ff + idx_ff[RING_AW-1:0];
      wr_data      = rd_data;
      rd_en        = 1'b0;
      rd_addr      = head_ff + idx_ff[RING_AW-1:0];
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               idx_in   = '0;
               pend_in  = 1'b0;
               state_in = (req_cmd == CMD_TICK) ? S_T_RD : S_F_RD;
            end
         end
         S_F_RD: begin
            if (idx_ff == count_ff) begin
               // id not held
               if (cmd_ff != CMD_ADD) begin
                  st_in    = ST_NOTFOUND;
                  state_in = S_EMIT;
               end else if (count_ff >= FULL_CNT) begin
                  st_in    = ST_FULL;
                  state_in = S_EMIT;
               end else begin
                  idx_in   = '0;
                  state_in = S_I_RD;
               end
            end else begin
               rd_en    = 1'b1;
               state_in = S_F_CHK;
            end
         end
         S_F_CHK: begin
            if (rd_conn == id_ff) begin
               if (cmd_ff == CMD_ADD) begin
                  st_in    = ST_DUP;
                  state_in = S_EMIT;
               end else begin
                  state_in = S_R_RD;
               end
            end else begin
               idx_in   = idx_p1;
               state_in = S_F_RD;
            end
         end
         S_R_RD: begin
            // shift the entries behind the removed one down by one
            if (idx_p1 >= count_ff) begin
               count_in = count_ff - cnt_type'(1);
               st_in    = ST_OK;
               idx_in   = '0;
               state_in = (cmd_ff == CMD_ADJUST) ? S_I_RD : S_EMIT;
            end else begin
               rd_en    = 1'b1;
               rd_addr  = head_ff + idx_p1[RING_AW-1:0];
               state_in = S_R_WR;
            end
         end
         S_R_WR: begin
            wr_en    = 1'b1;
            idx_in   = idx_p1;
            state_in = S_R_RD;
         end
         S_I_RD: begin
            if (idx_ff == count_ff) begin
               pos_in   = idx_ff;
               state_in = S_U_RD;
            end else begin
               rd_en    = 1'b1;
               state_in = S_I_CHK;
            end
         end
         S_I_CHK: begin
            if (rd_exp <= t_ff) begin
               idx_in   = idx_p1;
               state_in = S_I_RD;
            end else begin
               pos_in   = idx_ff;
               idx_in   = count_ff;
               state_in = S_U_RD;
            end
         end
         S_U_RD: begin
            if (idx_ff == pos_ff) begin
               wr_en    = 1'b1;
               wr_data  = {id_ff, t_ff};
               count_in = count_ff + cnt_type'(1);
               st_in    = ST_OK;
               state_in = S_EMIT;
            end else begin
               rd_en    = 1'b1;
               rd_addr  = head_ff + idx_m1[RING_AW-1:0];
               state_in = S_U_WR;
            end
         end
         S_U_WR: begin
            wr_en    = 1'b1;
            idx_in   = idx_m1;
            state_in = S_U_RD;
         end
         S_EMIT: begin
            if (out_free) begin
               emit     = 1'b1;
               e_status = st_ff;
               state_in = S_IDLE;
            end
         end
         S_T_RD: begin
            idx_in = '0;
            if (count_ff == '0) begin
               state_in = S_T_END;
            end else begin
               rd_en    = 1'b1;
               state_in = S_T_CHK;
            end
         end
         S_T_CHK: begin
            if (rd_exp > now_ff) begin
               state_in = S_T_END;
            end else if (!pend_ff || out_free) begin
               // hand over the previous expiry, hold this one until the next check
               if (pend_ff) begin
                  emit    = 1'b1;
                  e_valid = 1'b1;
                  e_conn  = pend_conn_ff;
                  e_occ   = pend_occ_ff;
                  e_last  = 1'b0;
               end
               pend_in      = 1'b1;
               pend_conn_in = rd_conn;
               pend_occ_in  = count_ff - cnt_type'(1);
               count_in     = count_ff - cnt_type'(1);
               head_in      = head_ff + RING_AW'(1);
               state_in     = S_T_RD;
            end
         end
         S_T_END: begin
            if (out_free) begin
               emit     = 1'b1;
               e_valid  = pend_ff;
               e_conn   = pend_ff ? pend_conn_ff : '0;
               e_occ    = pend_ff ? pend_occ_ff : count_ff;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         head_ff      <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         head_ff  <= head_in;
         pend_ff  <= pend_in;
         if (emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      idx_ff       <= idx_in;
      pos_ff       <= pos_in;
      st_ff        <= st_in;
      pend_conn_ff <= pend_conn_in;
      pend_occ_ff  <= pend_occ_in;
      if (accept) begin
         cmd_ff <= req_cmd;
         id_ff  <= req_conn_id;
         t_ff   <= req_expire_time;
         now_ff <= req_current_time;
      end
      if (emit) begin
         rsp_status_ff <= e_status;
         rsp_xv_ff     <= e_valid;
         rsp_conn_ff   <= e_conn;
         rsp_occ_ff    <= e_occ;
         rsp_last_ff   <= e_last;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_expired_valid = rsp_xv_ff;
   assign rsp_expired_conn  = rsp_conn_ff;
   assign rsp_occupancy     = rsp_occ_ff;
   assign rsp_last          = rsp_last_ff;
endmodule
`default_nettype wire

// File: verif/sorted_timer_expiry_queue_test.sv
`default_nettype none
module sorted_timer_expiry_queue_test;
   import steq_pkg::*;

   typedef struct packed {
      logic [1:0]  cmd;
      logic [15:0] conn_id;
      logic [31:0] expire_time;
      logic [31:0] current_time;
   } timer_op_type;

   typedef struct packed {
      logic [1:0]  status;
      logic        expired_valid;
      logic [15:0] expired_conn;
      logic [6:0]  occupancy;
      logic        last;
   } timer_rsp_type;

   // directed row: op plus an optional hand-written expectation
   typedef struct packed {
      timer_op_type  op;
      logic          typed;
      timer_rsp_type want;
   } dir_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [1:0]  req_cmd = CMD_ADD;
   logic [15:0] req_conn_id = '0;
   logic [31:0] req_expire_time = '0;
   logic [31:0] req_current_time = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [1:0]  rsp_status;
   logic        rsp_expired_valid;
   logic [15:0] rsp_expired_conn;
   logic [6:0]  rsp_occupancy;
   logic        rsp_last;

   sorted_timer_expiry_queue uut (.*);

   always #10 clock = ~clock;

   // predictor state
   logic [15:0]   timer_conn[MAX_TIMERS];
   logic [31:0]   timer_expiry[MAX_TIMERS];
   int            timer_count;
   timer_rsp_type pending_rsp[$];
   timer_rsp_type typed_rsp[$];

   int mismatches = 0;
   int rsp_seen = 0;
   int expired_seen = 0;
   int items_sent = 0;
   int cycle = 0;
   bit quiet_phase = 0;
   int limit = 3000000;

   function automatic int find_conn(logic [15:0] id);
      for (int i = 0; i < timer_count; i++)
         if (timer_conn[i] == id) return i;
      return -1;
   endfunction

   function automatic void take_out(int pos);
      for (int i = pos; i + 1 < timer_count; i++) begin
         timer_conn[i] = timer_conn[i+1];
         timer_expiry[i] = timer_expiry[i+1];
      end
      timer_count--;
   endfunction

   function automatic void place_sorted(logic [15:0] id, logic [31:0] t);
      int pos;
      pos = 0;
      while (pos < timer_count && timer_expiry[pos] <= t) pos++;
      for (int i = timer_count; i > pos; i--) begin
         timer_conn[i] = timer_conn[i-1];
         timer_expiry[i] = timer_expiry[i-1];
      end
      timer_conn[pos] = id;
      timer_expiry[pos] = t;
      timer_count++;
   endfunction

   function automatic timer_rsp_type mk_rsp(logic [1:0] st, logic v, logic [15:0] c,
                                            logic l);
      timer_rsp_type r;
      r.status = st;
      r.expired_valid = v;
      r.expired_conn = c;
      r.occupancy = timer_count[6:0];
      r.last = l;
      return r;
   endfunction

   function automatic void predict_timer_op(timer_op_type op);
      int pos, n;
      timer_rsp_type r;
      case (op.cmd)
         CMD_ADD: begin
            if (find_conn(op.conn_id) >= 0)
               pending_rsp.push_back(mk_rsp(ST_DUP, 0, 0, 1));
            else if (timer_count >= MAX_TIMERS)
               pending_rsp.push_back(mk_rsp(ST_FULL, 0, 0, 1));
            else begin
               place_sorted(op.conn_id, op.expire_time);
               pending_rsp.push_back(mk_rsp(ST_OK, 0, 0, 1));
            end
         end
         CMD_ADJUST, CMD_DELETE: begin
            pos = find_conn(op.conn_id);
            if (pos < 0)
               pending_rsp.push_back(mk_rsp(ST_NOTFOUND, 0, 0, 1));
            else begin
               take_out(pos);
               if (op.cmd == CMD_ADJUST) place_sorted(op.conn_id, op.expire_time);
               pending_rsp.push_back(mk_rsp(ST_OK, 0, 0, 1));
            end
         end
         default: begin
            n = 0;
            while (timer_count > 0 && timer_expiry[0] <= op.current_time) begin
               r.expired_conn = timer_conn[0];
               take_out(0);
               r = mk_rsp(ST_OK, 1, r.expired_conn, 0);
               r.last = (timer_count == 0 || timer_expiry[0] > op.current_time);
               pending_rsp.push_back(r);
               n++;
            end
            if (n == 0) pending_rsp.push_back(mk_rsp(ST_OK, 0, 0, 1));
         end
      endcase
   endfunction

   // result checking
   always @(posedge clock) begin
      timer_rsp_type got, want;
      cycle <= cycle + 1;
      if (!reset && rsp_valid && rsp_ready) begin
         got = {rsp_status, rsp_expired_valid, rsp_expired_conn, rsp_occupancy, rsp_last};
         rsp_seen++;
         if (rsp_expired_valid) expired_seen++;
         if (pending_rsp.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result %h", got);
         end else begin
            want = pending_rsp.pop_front();
            if (typed_rsp.size() > 0) begin
               if (typed_rsp[0] != want) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("predictor vs table: table %h pred %h", typed_rsp[0], want);
               end
               void'(typed_rsp.pop_front());
            end
            if (got != want) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: st %0d/%0d v %0d/%0d conn %h/%h occ %0d/%0d last %0d/%0d",
                           want.status, got.status, want.expired_valid, got.expired_valid,
                           want.expired_conn, got.expired_conn, want.occupancy,
                           got.occupancy, want.last, got.last);
            end
         end
      end
   end

   // receiver stalls
   always @(posedge clock) begin
      if (reset) rsp_ready <= 1'b0;
      else rsp_ready <= quiet_phase ? 1'b1 : ($urandom_range(99) >= 34);
   end

   always @(posedge clock) begin
      if (cycle > limit) begin
         $display("timeout after %0d cycles", cycle);
         $display("sorted_timer_expiry_queue_test: FAIL");
         $finish;
      end
   end

   // valid drops only when the sender idles, so back-to-back items keep it high
   task automatic send_op(timer_op_type op);
      if (!quiet_phase && $urandom_range(99) < 34) begin
         req_valid <= 1'b0;
         @(posedge clock);
         while (!quiet_phase && $urandom_range(99) < 34) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_cmd <= op.cmd;
      req_conn_id <= op.conn_id;
      req_expire_time <= op.expire_time;
      req_current_time <= op.current_time;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      predict_timer_op(op);
      items_sent++;
   endtask

   task automatic drain;
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_rsp.size() > 0) @(posedge clock);
   endtask

   function automatic timer_op_type mk_op(logic [1:0] c, logic [15:0] id, logic [31:0] t,
                                          logic [31:0] now);
      timer_op_type o;
      o.cmd = c; o.conn_id = id; o.expire_time = t; o.current_time = now;
      return o;
   endfunction

   function automatic timer_rsp_type rs(logic [1:0] st, logic v, logic [15:0] c,
                                        logic [6:0] occ, logic l);
      timer_rsp_type r;
      r.status = st; r.expired_valid = v; r.expired_conn = c; r.occupancy = occ;
      r.last = l;
      return r;
   endfunction

   // random op over a small id pool so hits, duplicates and misses all occur
   function automatic timer_op_type rand_op(int pool, logic [31:0] base);
      timer_op_type o;
      int k;
      k = $urandom_range(99);
      o.cmd = (k < 40) ? CMD_ADD : (k < 60) ? CMD_ADJUST : (k < 75) ? CMD_DELETE : CMD_TICK;
      o.conn_id = ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(pool - 1));
      o.expire_time = ($urandom_range(9) == 0) ? $urandom : base + $urandom_range(60);
      o.current_time = ($urandom_range(9) == 0) ? $urandom : base + $urandom_range(40);
      if ($urandom_range(19) == 0) o.expire_time[31] = 1'b1;
      return o;
   endfunction

   initial begin
      dir_row_type dir_table[$];
      dir_row_type row;
      logic [31:0] base;
      int n;

      dir_table.push_back('{mk_op(CMD_TICK, 0, 0, 0), 1, rs(ST_OK, 0, 0, 0, 1)});
      dir_table.push_back('{mk_op(CMD_DELETE, 16'hffff, 0, 0), 1,
                            rs(ST_NOTFOUND, 0, 0, 0, 1)});
      dir_table.push_back('{mk_op(CMD_ADJUST, 16'h0000, 5, 0), 1,
                            rs(ST_NOTFOUND, 0, 0, 0, 1)});
      dir_table.push_back('{mk_op(CMD_ADD, 16'hffff, 32'hffffffff, 0), 1,
                            rs(ST_OK, 0, 0, 1, 1)});
      dir_table.push_back('{mk_op(CMD_ADD, 16'hffff, 0, 0), 1, rs(ST_DUP, 0, 0, 1, 1)});
      dir_table.push_back('{mk_op(CMD_ADD, 16'h0000, 0, 0), 1, rs(ST_OK, 0, 0, 2, 1)});
      dir_table.push_back('{mk_op(CMD_ADD, 16'h1234, 100, 0), 0, '0});
      dir_table.push_back('{mk_op(CMD_ADD, 16'h1235, 100, 0), 0, '0});
      dir_table.push_back('{mk_op(CMD_ADD, 16'h1236, 50, 0), 0, '0});
      dir_table.push_back('{mk_op(CMD_ADJUST, 16'h1236, 100, 0), 0, '0});
      dir_table.push_back('{mk_op(CMD_ADJUST, 16'hffff, 1, 0), 0, '0});
      dir_table.push_back('{mk_op(CMD_DELETE, 16'h0000, 0, 0), 0, '0});
      dir_table.push_back('{mk_op(CMD_TICK, 0, 0, 99), 0, '0});
      dir_table.push_back('{mk_op(CMD_TICK, 0, 0, 100), 0, '0});
      dir_table.push_back('{mk_op(CMD_TICK, 0, 0, 32'hffffffff), 1,
                            rs(ST_OK, 0, 0, 0, 1)});
      dir_table.push_back('{mk_op(CMD_ADD, 16'h00aa, 32'hffffffff, 0), 0, '0});
      dir_table.push_back('{mk_op(CMD_TICK, 0, 0, 32'hffffffff), 1,
                            rs(ST_OK, 1, 16'h00aa, 0, 1)});

      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (dir_table[i]) begin
         row = dir_table[i];
         if (row.typed) begin
            drain();
            typed_rsp.push_back(row.want);
         end
         send_op(row.op);
      end
      drain();
      // typed rows are only valid when queue aligned; clear any residue
      typed_rsp.delete();

      // fill to full, hit full and duplicate, then expire everything at once
      for (int i = 0; i < MAX_TIMERS; i++)
         send_op(mk_op(CMD_ADD, 16'(i * 977), $urandom_range(20), 0));
      send_op(mk_op(CMD_ADD, 16'hbeef, 3, 0));
      send_op(mk_op(CMD_ADD, 16'(977), 3, 0));
      send_op(mk_op(CMD_TICK, 0, 0, 32'hffffffff));

      // random: mostly dense small-time traffic, with a quiet stretch
      base = 1000;
      n = 0;
      while (n < 380) begin
         if (n == 150) begin
            drain();
            quiet_phase = 1;
         end
         if (n == 210) quiet_phase = 0;
         if (n == 300) begin
            drain();
            base = 32'hffffff00;
         end
         send_op(rand_op((n % 100 < 50) ? 24 : 90, base));
         if ($urandom_range(9) == 0) base += $urandom_range(30);
         n++;
      end
      send_op(mk_op(CMD_TICK, 0, 0, 32'hffffffff));

      drain();
      repeat (300) @(posedge clock);
      $display("covered %0d items, %0d results of which %0d expirations",
               items_sent, rsp_seen, expired_seen);
      if (mismatches == 0 && pending_rsp.size() == 0)
         $display("sorted_timer_expiry_queue_test: PASS");
      else
         $display("sorted_timer_expiry_queue_test: FAIL");
      $finish;
   end
endmodule
`default_nettype wire
